>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl, removable with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

>>> rtl/core/asf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asf_pkg
// types and constants of the audio sample framer
// ---------------------------------------------------------------------------
package asf_pkg;

   localparam int MAX_SAMPLES = 128;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [15:0] CRC_START   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [11:0] SAMPLE_CEIL = 12'hFFF;

   // byte slots of one frame in stream order
   localparam logic [2:0] SLOT_SYNC1  = 3'd0;
   localparam logic [2:0] SLOT_SYNC2  = 3'd1;
   localparam logic [2:0] SLOT_SEQ    = 3'd2;
   localparam logic [2:0] SLOT_COUNT  = 3'd3;
   localparam logic [2:0] SLOT_LOW    = 3'd4;
   localparam logic [2:0] SLOT_HIGH   = 3'd5;
   localparam logic [2:0] SLOT_CRC_LO = 3'd6;
   localparam logic [2:0] SLOT_CRC_HI = 3'd7;

   typedef struct packed {
      logic [15:0] sample;
      logic        frame_start;
      logic [7:0]  frame_len;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       error;
   } rsp_item_type;

   // classified work for the back end
   typedef struct packed {
      logic        err;
      logic        start;
      logic        close;
      logic [7:0]  seq;
      logic [7:0]  count;
      logic [11:0] sample;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } q_head_type;

endpackage

>>> rtl/core/asf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asf_queue
// short job queue between the front and the back end
// ---------------------------------------------------------------------------
module asf_queue import asf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  job_type    wr_job,
   output logic       full,
   input  logic       rd_en,
   output q_head_type head
);

   job_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_wr, do_rd;

   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

>>> rtl/core/asf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asf_front
// accepts items, tracks frame state and classifies each item into a job
// ---------------------------------------------------------------------------
module asf_front import asf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type item,
   output logic         job_valid,
   output job_type      job
);

   logic [7:0] seq_ff, seq_in;
   logic [7:0] left_ff, left_in;
   logic       open_ff, open_in;
   logic       bad_count;
   logic [7:0] left_next;

   assign bad_count = (item.frame_len == 8'd0) || (item.frame_len > 8'(MAX_SAMPLES));

   always_comb begin
      seq_in  = seq_ff;
      left_in = left_ff;
      open_in = open_ff;

      job.err    = 1'b0;
      job.start  = item.frame_start;
      job.seq    = seq_ff;
      job.count  = item.frame_len;
      job.sample = (item.sample > 16'(SAMPLE_CEIL)) ? SAMPLE_CEIL : item.sample[11:0];

      left_next = item.frame_start ? item.frame_len - 8'd1 : left_ff - 8'd1;
      job.close = (left_next == 8'd0);

      if ((item.frame_start && bad_count) || (!item.frame_start && !open_ff)) begin
         job.err = 1'b1;
      end else if (accept) begin
         left_in = left_next;
         open_in = !job.close;
         if (job.close) begin
            seq_in = seq_ff + 8'd1;
         end
      end
   end

   assign job_valid = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         left_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         seq_ff  <= seq_in;
         left_ff <= left_in;
         open_ff <= open_in;
      end
   end

endmodule

>>> rtl/core/asf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// asf_back
// walks each job through its byte slots, keeps the crc, registers results
// ---------------------------------------------------------------------------
module asf_back import asf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_head_type   head,
   output logic         job_done,
   output logic         rsp_empty,
   output rsp_item_type rsp_item,
   input  logic         rsp_pop
);

   logic [2:0]   step_ff, step_in;
   logic [15:0]  crc_ff, crc_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   logic [2:0]   idx;
   logic         last, adv;
   logic [7:0]   data;
   logic [15:0]  crc_base;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // continuing samples skip the header slots
   assign idx  = head.job.start ? step_ff : step_ff + SLOT_LOW;
   assign last = head.job.err || (idx == (head.job.close ? SLOT_CRC_HI : SLOT_HIGH));
   assign adv  = head.valid && (!out_valid_ff || rsp_pop);
   assign job_done = adv && last;

   always_comb begin
      case (idx)
         SLOT_SYNC1:  data = SYNC_FIRST;
         SLOT_SYNC2:  data = SYNC_SECOND;
         SLOT_SEQ:    data = head.job.seq;
         SLOT_COUNT:  data = head.job.count;
         SLOT_LOW:    data = head.job.sample[7:0];
         SLOT_HIGH:   data = {4'h0, head.job.sample[11:8]};
         SLOT_CRC_LO: data = crc_ff[7:0];
         SLOT_CRC_HI: data = crc_ff[15:8];
         default:     data = 8'h00;
      endcase
   end

   always_comb begin
      crc_base     = (idx == SLOT_SEQ) ? CRC_START : crc_ff;
      crc_in       = crc_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (adv) begin
         out_valid_in = 1'b1;
         step_in      = last ? 3'd0 : step_ff + 3'd1;
         if (head.job.err) begin
            out_in.out_byte  = 8'h00;
            out_in.frame_end = 1'b0;
            out_in.run_last  = 1'b1;
            out_in.error     = 1'b1;
         end else begin
            out_in.out_byte  = data;
            out_in.frame_end = (idx == SLOT_CRC_HI);
            out_in.run_last  = last;
            out_in.error     = 1'b0;
            if (idx == SLOT_SEQ || idx == SLOT_COUNT || idx == SLOT_LOW
                || idx == SLOT_HIGH) begin
               crc_in = crc_feed(crc_base, data);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         crc_ff       <= CRC_START;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

>>> rtl/core/audio_sample_framer_crc16.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_sample_framer_crc16
// packs audio samples into sync/seq/count/sample frames closed by a crc-16
// ---------------------------------------------------------------------------
//
//  channel   ports                        moves
//  request   push, full, req_item         one sample item per accept
//  response  empty, pop, rsp_item         one frame byte or error per accept
//
//  the front takes an item in any cycle the job queue has room (four deep)
//  the back end emits one byte per cycle while the response side keeps popping; the output byte register sets the rate
//  a continuing sample emits its low and high bytes, then the crc bytes when it closes the frame; an opening
//  sample emits sync, seq and count before them; a rejected item emits one error result
//  synchronous reset clears frame state, queue and output; no clearing pass
//  a stalled response stops the back end while the queue keeps filling
//
module audio_sample_framer_crc16 import asf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

`include "assert_macros.svh"

   logic       accept;
   logic       job_push;
   job_type    job;
   q_head_type head;
   logic       job_done;

   // item accepted only when the queue has room
   assign accept = push && !full;

   // front: frame bookkeeping and classification
   asf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (req_item),
      .job_valid (job_push),
      .job       (job)
   );

   // decoupling queue between front and back
   asf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_push),
      .wr_job (job),
      .full   (full),
      .rd_en  (job_done),
      .head   (head)
   );

   // back: byte sequencing, crc and output register
   asf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .job_done  (job_done),
      .rsp_empty (empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (pop)
   );

   // an accepted item is waiting in the queue on the next cycle
   `ASSERT_CLK(a_job_queued, clock, reset, accept |=> head.valid, "accepted item lost")
   // a frame only ends on the last byte of an item
   `ASSERT_NEVER(a_end_last, clock, reset, !empty && rsp_item.frame_end && !rsp_item.run_last, "frame end not last")
   // error results are single and carry no byte
   `ASSERT_NEVER(a_err_form, clock, reset, !empty && rsp_item.error && (!rsp_item.run_last || rsp_item.out_byte != 8'h00 || rsp_item.frame_end), "malformed error result")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the audio sample framer with crc-16 trailer
// ---------------------------------------------------------------------------
//
// sample items go in through the push/full side and frame bytes come back
// through the empty/pop side. a small scoreboard class keeps its own copy
// of the frame state (sequence number, running crc, samples left, open
// flag), expands every accepted item into the bytes it must produce, and
// checks each popped byte against the oldest one still owed. a directed
// opening covers the error cases, clamping, restart and the bad-count case
// inside an open frame; random frames with noise follow, with random gaps
// on the push side and random stalls on the pop side
//
module tb_top;
   import asf_pkg::*;

   localparam int ITEM_GOAL  = 420;
   localparam int DRAIN_WAIT = 20;

   // scoreboard: predicts frame bytes per sample item and checks them
   class frame_scoreboard;
      rsp_item_type owed_bytes[$];
      logic [7:0]   seq_no;
      logic [15:0]  crc_run;
      logic [7:0]   left;
      logic         open;
      int           mismatches;
      int           bytes_checked;
      int           errors_seen;
      int           frames_closed;

      function new();
         seq_no        = '0;
         crc_run       = CRC_START;
         left          = '0;
         open          = 1'b0;
         mismatches    = 0;
         bytes_checked = 0;
         errors_seen   = 0;
         frames_closed = 0;
      endfunction

      // crc-16/ccitt-false, msb first, one byte
      function void crc_byte(input logic [7:0] b);
         logic [15:0] c;
         c = crc_run ^ {b, 8'h00};
         for (int i = 0; i < 8; i++) begin
            if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
            else c = {c[14:0], 1'b0};
         end
         crc_run = c;
      endfunction

      function void note_item(input req_item_type it);
         rsp_item_type burst[$];
         rsp_item_type r;
         logic [11:0]  s;
         r = '0;
         if (it.frame_start) begin
            if (it.frame_len == 8'd0 || int'(it.frame_len) > MAX_SAMPLES) begin
               // bad count: one error, frame state untouched
               r.error = 1'b1;
               burst.push_back(r);
            end else begin
               // a restart abandons any open frame, sequence number reused
               crc_run = CRC_START;
               r.out_byte = SYNC_FIRST;
               burst.push_back(r);
               r.out_byte = SYNC_SECOND;
               burst.push_back(r);
               r.out_byte = seq_no;
               burst.push_back(r);
               crc_byte(seq_no);
               r.out_byte = it.frame_len;
               burst.push_back(r);
               crc_byte(it.frame_len);
               left = it.frame_len;
               open = 1'b1;
            end
         end else if (!open) begin
            // sample with no frame open
            r.error = 1'b1;
            burst.push_back(r);
         end
         if (burst.size() == 0 || !burst[0].error) begin
            s = (it.sample > 16'd4095) ? SAMPLE_CEIL : it.sample[11:0];
            r = '0;
            r.out_byte = s[7:0];
            burst.push_back(r);
            crc_byte(s[7:0]);
            r.out_byte = {4'h0, s[11:8]};
            burst.push_back(r);
            crc_byte({4'h0, s[11:8]});
            left = left - 8'd1;
            if (left == 8'd0) begin
               r.out_byte = crc_run[7:0];
               burst.push_back(r);
               r.out_byte  = crc_run[15:8];
               r.frame_end = 1'b1;
               burst.push_back(r);
               seq_no = seq_no + 8'd1;
               open   = 1'b0;
            end
         end
         burst[burst.size() - 1].run_last = 1'b1;
         foreach (burst[i]) owed_bytes.push_back(burst[i]);
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type want;
         if (owed_bytes.size() == 0) begin
            $error("unexpected result: out_byte %02h frame_end %0b run_last %0b error %0b",
                   got.out_byte, got.frame_end, got.run_last, got.error);
            mismatches++;
            return;
         end
         want = owed_bytes.pop_front();
         bytes_checked++;
         if (want.error) errors_seen++;
         if (want.frame_end) frames_closed++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
            mismatches++;
         end
         if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            mismatches++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, got.error);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   req_item_type req_item;
   logic         empty;
   logic         pop;
   rsp_item_type rsp_item;

   frame_scoreboard frames;
   int  items_sent;
   int  pop_hold;
   bit  gaps_on;
   bit  stalls_on;

   audio_sample_framer_crc16 u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always #5 clock = ~clock;

   // mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // sample values weighted toward the clamp boundary and the extremes
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: begin
            return 16'($urandom_range(0, 4095));
         end
         4, 5: begin
            return 16'($urandom_range(4096, 65535));
         end
         6: begin
            case ($urandom_range(0, 3))
               0: return 16'd0;
               1: return 16'd4095;
               2: return 16'd4096;
               default: return 16'hFFFF;
            endcase
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // offer one item, hold it until accepted, then maybe leave a gap
   task automatic push_item(input logic [15:0] smp, input logic start, input logic [7:0] cnt);
      req_item_type it;
      it.sample       = smp;
      it.frame_start  = start;
      it.frame_len    = cnt;
      push     <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!(push && !full));
      frames.note_item(it);
      items_sent++;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         push <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // well-formed frame with random content; may be cut short on purpose or carry bad-count items
   task automatic send_frame(input int cnt);
      push_item(pick_sample(), 1'b1, 8'(cnt));
      for (int i = 1; i < cnt; i++) begin
         if ($urandom_range(0, 99) < 2) return;
         if ($urandom_range(0, 99) < 3)
            push_item(pick_sample(), 1'b1, 8'($urandom_range(MAX_SAMPLES + 1, 255)));
         push_item(pick_sample(), 1'b0, 8'($urandom));
      end
   endtask

   // result side: pop with random stalls, check every accepted byte
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (pop && !empty) frames.check_result(rsp_item);
         if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            pop      <= 1'b0;
            pop_hold <= pick_gap() - 1;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // run limit: far above the slowest legal run
   initial begin
      #20_000_000;
      $display("** audio_sample_framer_crc16: FAILED **");
      $finish;
   end

   initial begin
      int r;
      int cnt;
      int big_frames;
      clock      = 1'b0;
      reset      = 1'b1;
      push       = 1'b0;
      pop        = 1'b0;
      req_item   = '0;
      pop_hold   = 0;
      items_sent = 0;
      big_frames = 0;
      gaps_on    = 1'b1;
      stalls_on  = 1'b1;
      frames     = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: error cases first, nothing open yet
      push_item(16'hFFFF, 1'b0, 8'h00);         // sample with no frame
      push_item(16'h0000, 1'b1, 8'd0);          // zero count
      push_item(16'h1234, 1'b1, 8'd129);        // just over the maximum
      push_item(16'h0000, 1'b1, 8'd255);        // largest count field
      // one-sample frames, zero and clamped
      push_item(16'h0000, 1'b1, 8'd1);
      push_item(16'hFFFF, 1'b1, 8'd1);
      // clamp boundary inside a frame; count ignored on later samples
      push_item(16'd4095, 1'b1, 8'd3);
      push_item(16'd4096, 1'b0, 8'hFF);
      push_item(16'h8000, 1'b0, 8'h00);
      // bad count inside an open frame leaves it open
      push_item(16'h0ABC, 1'b1, 8'd4);
      push_item(16'h0123, 1'b0, 8'h55);
      push_item(16'h0456, 1'b1, 8'd200);
      push_item(16'h0FFE, 1'b0, 8'hAA);
      // restart abandons the open frame and reuses its sequence number
      push_item(16'h0001, 1'b1, 8'd2);
      push_item(16'h7FFF, 1'b0, 8'h0F);
      push_item(16'h00FF, 1'b1, 8'd2);
      push_item(16'h0F00, 1'b0, 8'hF0);
      // sample right after a closed frame
      push_item(16'h5555, 1'b0, 8'h80);

      // one frame of the largest size, back to back on both sides
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_frame(MAX_SAMPLES);
      big_frames++;

      // random frames with noise; idling toggles between stretches
      while (items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 5) == 0) begin
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
         end
         r = $urandom_range(0, 99);
         if (r < 85) begin
            r = $urandom_range(0, 99);
            if (r < 45) cnt = $urandom_range(1, 4);
            else if (r < 85) cnt = $urandom_range(5, 16);
            else if (r < 98 || big_frames >= 2) cnt = $urandom_range(17, 40);
            else begin
               cnt = MAX_SAMPLES;
               big_frames++;
            end
            send_frame(cnt);
         end else if (r < 92) begin
            push_item(pick_sample(), 1'b0, 8'($urandom));
         end else if (r < 95) begin
            push_item(pick_sample(), 1'b1, 8'd0);
         end else begin
            push_item(pick_sample(), 1'b1, 8'($urandom_range(MAX_SAMPLES + 1, 255)));
         end
      end
      push <= 1'b0;

      // drain with the pop side open, then watch for stray bytes
      stalls_on = 1'b0;
      while (frames.owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d sample items, %0d result bytes checked", items_sent,
               frames.bytes_checked);
      $display("%0d frames closed, %0d rejected items, %0d mismatches", frames.frames_closed,
               frames.errors_seen, frames.mismatches);
      if (frames.mismatches == 0) begin
         $display("** audio_sample_framer_crc16: PASSED **");
      end else begin
         $display("** audio_sample_framer_crc16: FAILED **");
      end
      $finish;
   end

endmodule
